>>> sv/ellrast_pkg.sv
// Shared types for the ellipse rasterizer: command and status bundles
// between controller and datapath, and the request function codes.
// No dependencies.
`default_nettype none

package ellrast_pkg;

   // Request function codes.
   typedef enum logic {
      FUNC_START = 1'b0,
      FUNC_STEP  = 1'b1
   } func_type;

   // Controller to datapath: one strobe per kind of work.
   typedef struct packed {
      logic load_req;   // capture the corners of an accepted beat
      logic set1;       // box extents and columns
      logic set2;       // squares, rows, height
      logic set3;       // increments and growths
      logic set4;       // initial error term, enter main loop
      logic main_a;     // row half of a main step
      logic main_b;     // column half of a main step, end check
      logic tip;        // one tip step
      logic load_out;   // move the finished group into the output register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic phase_main;
      logic phase_tip;
   } sts_type;

endpackage

`default_nettype wire

>>> sv/ellrast_dp.sv
// Datapath of the ellipse rasterizer: setup arithmetic, error term,
// positions and the output register. Uses ellrast_pkg.
`default_nettype none

module ellrast_dp #(
   parameter int COORD_BITS = 12,
   parameter int ERR_BITS   = 48
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ellrast_pkg::cmd_type          cmd,
   output ellrast_pkg::sts_type               sts,
   input  wire logic [COORD_BITS-1:0]         req_corner_x0,
   input  wire logic [COORD_BITS-1:0]         req_corner_y0,
   input  wire logic [COORD_BITS-1:0]         req_corner_x1,
   input  wire logic [COORD_BITS-1:0]         req_corner_y1,
   output logic signed [COORD_BITS+1:0]       rsp_left_col,
   output logic signed [COORD_BITS+1:0]       rsp_right_col,
   output logic signed [COORD_BITS+1:0]       rsp_down_row,
   output logic signed [COORD_BITS+1:0]       rsp_up_row,
   output logic                               rsp_last
);
   import ellrast_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int E  = ERR_BITS;
   localparam int P  = COORD_BITS + 2;
   localparam int PW = 3 * COORD_BITS + 2;
   localparam int GW = (ERR_BITS < 2 * COORD_BITS + 3) ? ERR_BITS : 2 * COORD_BITS + 3;

   localparam logic [P-1:0] POS_ONE = P'(1);

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_MAIN = 3'b010,
      PH_TIP  = 3'b100
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [C-1:0]     x0_ff, y0_ff, x1_ff, y1_ff;
   logic [C-1:0]     x0_in, y0_in, x1_in, y1_in;
   logic [C-1:0]     a_ff, b_ff, top_ff, a_in, b_in, top_in;
   logic [2*C-1:0]   aa_ff, bb_ff, aa_in, bb_in;
   logic [P-1:0]     left_ff, right_ff, down_ff, up_ff;
   logic [P-1:0]     left_in, right_in, down_in, up_in;
   logic [C-1:0]     height_ff, height_in;
   logic [E-1:0]     err_ff, xinc_ff, yinc_ff, err_in, xinc_in, yinc_in;
   logic [GW-1:0]    xg_ff, yg_ff, xg_in, yg_in;
   logic             c_ge_ff, c_ge_in;
   logic [P-1:0]     res_left_ff, res_right_ff, res_down_ff, res_up_ff;
   logic [P-1:0]     res_left_in, res_right_in, res_down_in, res_up_in;
   logic             res_last_ff, res_last_in;
   logic [P-1:0]     out_left_ff, out_right_ff, out_down_ff, out_up_ff;
   logic [P-1:0]     out_left_in, out_right_in, out_down_in, out_up_in;
   logic             out_last_ff, out_last_in;

   // Setup terms
   logic [C:0]       b_plus1;
   logic [2*C-1:0]   a_ext, b_ext;
   logic [2*C-1:0]   aa_prod, bb_prod;
   logic [PW-1:0]    a_wide, bb_wide, ab_prod, xprod;
   logic [E+PW+1:0]  xinc_wide;
   logic [E+2*C+2:0] yinc_wide, xg_wide, yg_wide;
   logic [E+2*C-1:0] oddaa_wide;
   logic [E-1:0]     oddaa;

   // Step terms
   logic [E+GW-1:0]  xg_ext_wide, yg_ext_wide;
   logic [E-1:0]     xg_e, yg_e;
   logic [E:0]       e_twice, y_sext, x_sext;
   logic             c_le, c_ge, c2;
   logic [E-1:0]     yinc_up, xinc_up, err_y, err_x;
   logic [P-1:0]     left_inc, right_dec, down_inc, up_dec, left_dec, right_inc;
   logic             gt_step, gt_hold, gt;
   logic [P:0]       span, span_post, height_ext;
   logic             narrow, tip_done;

   assign b_plus1     = {1'b0, b_ff} + {{C{1'b0}}, 1'b1};
   assign a_ext       = {{C{1'b0}}, a_ff};
   assign b_ext       = {{C{1'b0}}, b_ff};
   assign aa_prod     = a_ext * a_ext;
   assign bb_prod     = b_ext * b_ext;
   // (1 - a) * b * b, formed as b*b - a*b*b so the product stays unsigned
   assign a_wide      = {{(2*C+2){1'b0}}, a_ff};
   assign bb_wide     = {{(C+2){1'b0}}, bb_ff};
   assign ab_prod     = a_wide * bb_wide;
   assign xprod       = bb_wide - ab_prod;
   assign xinc_wide   = {{E{xprod[PW-1]}}, xprod, 2'b00};
   assign yinc_wide   = b_ff[0] ? {{E{1'b0}}, aa_ff, 3'b000}
                                : {{(E+1){1'b0}}, aa_ff, 2'b00};
   assign xg_wide     = {{E{1'b0}}, bb_ff, 3'b000};
   assign yg_wide     = {{E{1'b0}}, aa_ff, 3'b000};
   assign oddaa_wide  = {{E{1'b0}}, aa_ff};
   assign oddaa       = b_ff[0] ? oddaa_wide[E-1:0] : '0;

   assign xg_ext_wide = {{E{1'b0}}, xg_ff};
   assign yg_ext_wide = {{E{1'b0}}, yg_ff};
   assign xg_e        = xg_ext_wide[E-1:0];
   assign yg_e        = yg_ext_wide[E-1:0];

   // Compare 2*e against an increment one bit wider, so nothing overflows.
   assign e_twice = {err_ff, 1'b0};
   assign y_sext  = {yinc_ff[E-1], yinc_ff};
   assign x_sext  = {xinc_ff[E-1], xinc_ff};
   assign c_le    = $signed(e_twice) <= $signed(y_sext);
   assign c_ge    = $signed(e_twice) >= $signed(x_sext);
   assign c2      = c_ge_ff || !c_le;

   assign yinc_up = yinc_ff + yg_e;
   assign err_y   = err_ff + yinc_ff + yg_e;
   assign xinc_up = xinc_ff + xg_e;
   assign err_x   = err_ff + xinc_ff + xg_e;

   assign left_inc  = left_ff + POS_ONE;
   assign right_dec = right_ff - POS_ONE;
   assign left_dec  = left_ff - POS_ONE;
   assign right_inc = right_ff + POS_ONE;
   assign down_inc  = down_ff + POS_ONE;
   assign up_dec    = up_ff - POS_ONE;

   assign gt_step    = $signed(left_inc) > $signed(right_dec);
   assign gt_hold    = $signed(left_ff) > $signed(right_ff);
   assign gt         = c2 ? gt_step : gt_hold;
   assign height_ext = {3'b000, height_ff};
   assign span       = {down_ff[P-1], down_ff} - {up_ff[P-1], up_ff};
   assign span_post  = {down_inc[P-1], down_inc} - {up_dec[P-1], up_dec};
   assign narrow     = $signed(span) < $signed(height_ext);
   assign tip_done   = !($signed(span_post) < $signed(height_ext));

   always_comb begin
      phase_in     = phase_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      top_in       = top_ff;
      aa_in        = aa_ff;
      bb_in        = bb_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      down_in      = down_ff;
      up_in        = up_ff;
      height_in    = height_ff;
      err_in       = err_ff;
      xinc_in      = xinc_ff;
      yinc_in      = yinc_ff;
      xg_in        = xg_ff;
      yg_in        = yg_ff;
      c_ge_in      = c_ge_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      res_down_in  = res_down_ff;
      res_up_in    = res_up_ff;
      res_last_in  = res_last_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_down_in  = out_down_ff;
      out_up_in    = out_up_ff;
      out_last_in  = out_last_ff;

      if (cmd.load_req) begin
         x0_in = req_corner_x0;
         y0_in = req_corner_y0;
         x1_in = req_corner_x1;
         y1_in = req_corner_y1;
      end

      if (cmd.set1) begin
         a_in     = (x1_ff > x0_ff) ? x1_ff - x0_ff : x0_ff - x1_ff;
         b_in     = (y1_ff > y0_ff) ? y1_ff - y0_ff : y0_ff - y1_ff;
         top_in   = (y0_ff < y1_ff) ? y0_ff : y1_ff;
         left_in  = {2'b00, ((x0_ff < x1_ff) ? x0_ff : x1_ff)};
         right_in = {2'b00, ((x0_ff < x1_ff) ? x1_ff : x0_ff)};
      end

      if (cmd.set2) begin
         aa_in     = aa_prod;
         bb_in     = bb_prod;
         // up row sits b/2 below top, down row (b+1)/2 below top
         down_in   = {2'b00, top_ff} + {2'b00, b_plus1[C:1]};
         up_in     = {2'b00, top_ff} + {3'b000, b_ff[C-1:1]};
         height_in = b_ff;
      end

      if (cmd.set3) begin
         xinc_in = xinc_wide[E-1:0];
         yinc_in = yinc_wide[E-1:0];
         xg_in   = xg_wide[GW-1:0];
         yg_in   = yg_wide[GW-1:0];
      end

      if (cmd.set4) begin
         err_in   = xinc_ff + yinc_ff + oddaa;
         phase_in = PH_MAIN;
      end

      if (cmd.main_a) begin
         res_left_in  = left_ff;
         res_right_in = right_ff;
         res_down_in  = down_ff;
         res_up_in    = up_ff;
         res_last_in  = 1'b0;
         c_ge_in      = c_ge;
         if (c_le) begin
            down_in = down_inc;
            up_in   = up_dec;
            yinc_in = yinc_up;
            err_in  = err_y;
         end
      end

      if (cmd.main_b) begin
         if (c2) begin
            left_in  = left_inc;
            right_in = right_dec;
            xinc_in  = xinc_up;
            err_in   = err_x;
         end
         if (gt) begin
            phase_in    = narrow ? PH_TIP : PH_IDLE;
            res_last_in = !narrow;
         end
      end

      if (cmd.tip) begin
         res_left_in  = left_dec;
         res_right_in = right_inc;
         res_down_in  = down_ff;
         res_up_in    = up_ff;
         res_last_in  = tip_done;
         down_in      = down_inc;
         up_in        = up_dec;
         if (tip_done) begin
            phase_in = PH_IDLE;
         end
      end

      if (cmd.load_out) begin
         out_left_in  = res_left_ff;
         out_right_in = res_right_ff;
         out_down_in  = res_down_ff;
         out_up_in    = res_up_ff;
         out_last_in  = res_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      top_ff       <= top_in;
      aa_ff        <= aa_in;
      bb_ff        <= bb_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      down_ff      <= down_in;
      up_ff        <= up_in;
      height_ff    <= height_in;
      err_ff       <= err_in;
      xinc_ff      <= xinc_in;
      yinc_ff      <= yinc_in;
      xg_ff        <= xg_in;
      yg_ff        <= yg_in;
      c_ge_ff      <= c_ge_in;
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      res_down_ff  <= res_down_in;
      res_up_ff    <= res_up_in;
      res_last_ff  <= res_last_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_down_ff  <= out_down_in;
      out_up_ff    <= out_up_in;
      out_last_ff  <= out_last_in;
   end

   assign sts.phase_main = (phase_ff == PH_MAIN);
   assign sts.phase_tip  = (phase_ff == PH_TIP);

   assign rsp_left_col  = $signed(out_left_ff);
   assign rsp_right_col = $signed(out_right_ff);
   assign rsp_down_row  = $signed(out_down_ff);
   assign rsp_up_row    = $signed(out_up_ff);
   assign rsp_last      = out_last_ff;

endmodule

`default_nettype wire

>>> sv/ellrast_ctrl.sv
// Controller of the ellipse rasterizer: sequences setup and step work,
// owns the handshakes and the output valid flag. Uses ellrast_pkg.
`default_nettype none

module ellrast_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_func,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire ellrast_pkg::sts_type sts,
   output ellrast_pkg::cmd_type      cmd
);
   import ellrast_pkg::*;

   typedef enum logic [8:0] {
      ST_READY  = 9'b000000001,
      ST_SET1   = 9'b000000010,
      ST_SET2   = 9'b000000100,
      ST_SET3   = 9'b000001000,
      ST_SET4   = 9'b000010000,
      ST_MAIN_A = 9'b000100000,
      ST_MAIN_B = 9'b001000000,
      ST_TIP    = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_READY: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               priority if (req_func == FUNC_START) begin
                  state_in = ST_SET1;
               end else if (sts.phase_main) begin
                  state_in = ST_MAIN_A;
               end else if (sts.phase_tip) begin
                  state_in = ST_TIP;
               end else begin
                  state_in = ST_READY;
               end
            end
         end
         ST_SET1: begin
            cmd.set1 = 1'b1;
            state_in = ST_SET2;
         end
         ST_SET2: begin
            cmd.set2 = 1'b1;
            state_in = ST_SET3;
         end
         ST_SET3: begin
            cmd.set3 = 1'b1;
            state_in = ST_SET4;
         end
         ST_SET4: begin
            cmd.set4 = 1'b1;
            state_in = ST_READY;
         end
         ST_MAIN_A: begin
            cmd.main_a = 1'b1;
            state_in   = ST_MAIN_B;
         end
         ST_MAIN_B: begin
            cmd.main_b = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_TIP: begin
            cmd.tip  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_READY;
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   // Set on load, hold while the receiver stalls, drop once taken.
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_READY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_READY);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> sv/ellipse_rasterizer_unit.sv
// Top level of the ellipse rasterizer: controller plus datapath.
// Depends on ellrast_pkg, ellrast_ctrl and ellrast_dp.
//
// Usage: rasterizes the axis-aligned ellipse inscribed in a box, one
// group of four symmetric points per beat.
// - Request channel (req_): a start beat (func 0) takes two corners in
//   either order; a step beat (func 1) asks for the next point group.
//   A step beat while no ellipse is active is consumed and gives nothing.
//   A start beat while drawing abandons the current ellipse.
// - Result channel (rsp_): left/right columns, down/up rows and last,
//   which marks the final group of the ellipse.
// - Sequencing: a start beat keeps the block busy through its setup steps
//   (square and cross-product multipliers), then it is ready again.
//   A main-loop step is a row half and a column half, each one 48-bit
//   three-input add and compare, then the move into the output
//   register, after which its group is on rsp_. A tip step does the
//   tip update, then the same move; an idle step leaves the block ready.
// - While rsp_stall is high the group holds in the output register; the
//   block still takes the next request beat and works it up to the point
//   where it needs the output register, then holds.
// - Reset (synchronous, active high) drops any pending result and returns
//   the block to no active ellipse; a start beat is needed before steps.
`default_nettype none

module ellipse_rasterizer_unit #(
   parameter int COORD_BITS = 12,
   parameter int ERR_BITS   = 48
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_func,
   input  wire logic [COORD_BITS-1:0]     req_corner_x0,
   input  wire logic [COORD_BITS-1:0]     req_corner_y0,
   input  wire logic [COORD_BITS-1:0]     req_corner_x1,
   input  wire logic [COORD_BITS-1:0]     req_corner_y1,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [COORD_BITS+1:0]   rsp_left_col,
   output logic signed [COORD_BITS+1:0]   rsp_right_col,
   output logic signed [COORD_BITS+1:0]   rsp_down_row,
   output logic signed [COORD_BITS+1:0]   rsp_up_row,
   output logic                           rsp_last
);
   import ellrast_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencing and handshakes.
   ellrast_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Setup arithmetic, error term, positions, output register.
   ellrast_dp #(
      .COORD_BITS (COORD_BITS),
      .ERR_BITS   (ERR_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_corner_x0 (req_corner_x0),
      .req_corner_y0 (req_corner_y0),
      .req_corner_x1 (req_corner_x1),
      .req_corner_y1 (req_corner_y1),
      .rsp_left_col  (rsp_left_col),
      .rsp_right_col (rsp_right_col),
      .rsp_down_row  (rsp_down_row),
      .rsp_up_row    (rsp_up_row),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

>>> sv/ellrast_chk.sv
// Port-level checks for ellipse_rasterizer_unit, attached by bind.
// Uses ellrast_pkg.
`default_nettype none

module ellrast_chk #(
   parameter int COORD_BITS = 12
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire logic                    req_func,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic [COORD_BITS+1:0]   rsp_left_col,
   input wire logic [COORD_BITS+1:0]   rsp_right_col,
   input wire logic [COORD_BITS+1:0]   rsp_down_row,
   input wire logic [COORD_BITS+1:0]   rsp_up_row,
   input wire logic                    rsp_last
);
   import ellrast_pkg::*;

   // Reset drops any pending result.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat valid right after reset");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_left_col)
         && $stable(rsp_right_col) && $stable(rsp_down_row)
         && $stable(rsp_up_row) && $stable(rsp_last)))
      else $error("stalled result beat changed");

   // A new result appears only from a busy cycle of the block.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat appeared while the block was ready");

   // Start setup occupies the block after the start beat.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func == FUNC_START)) |=> req_stall)
      else $error("block ready right after a start beat");

endmodule

bind ellipse_rasterizer_unit ellrast_chk #(.COORD_BITS(COORD_BITS)) u_chk (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for ellipse_rasterizer_unit: start and step beats in,
// point groups out, each group compared with a built-in raster predictor.
// Depends on ellrast_pkg and the unit's RTL; reads no files.
module tb_top;
   import ellrast_pkg::*;

   localparam int COORD_W     = 12;
   localparam int POS_W       = COORD_W + 2;
   localparam int ERR_W       = 48;
   localparam int COORD_MAX   = (1 << COORD_W) - 1;
   localparam int QUIET_LIMIT = 3000;   // cycles without any beat before giving up
   localparam int TAIL_CYCLES = 20;     // quiet time after the drain; allow plenty
   localparam int PHASE_ITEMS = 132;    // counted beats per idle/stall mix
   localparam int TABLE_ROWS  = 25;

   typedef enum logic [1:0] {DRAW_IDLE, DRAW_MAIN, DRAW_TIP} draw_phase_type;

   // How a stimulus row gets its expectation: from the predictor, typed
   // in as "no group", or typed in as a single-point group.
   typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_GROUP} row_kind_type;

   typedef struct packed {
      logic signed [POS_W-1:0] left, right, down, up;
      logic                    last;
   } point_group_type;

   typedef struct packed {
      row_kind_type       kind;
      func_type           func;
      logic [COORD_W-1:0] x0, y0, x1, y1;
      point_group_type    want;
   } stim_row_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_func;
   logic [COORD_W-1:0]       req_corner_x0, req_corner_y0, req_corner_x1, req_corner_y1;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [POS_W-1:0]  rsp_left_col, rsp_right_col, rsp_down_row, rsp_up_row;
   logic                     rsp_last;

   // Predictor state: mirrors the unit's raster registers.
   draw_phase_type          draw_phase = DRAW_IDLE;
   logic signed [POS_W-1:0] left_at = '0, right_at = '0, down_at = '0, up_at = '0;
   int                      box_height = 0;
   longint                  err_acc = 0, x_inc = 0, y_inc = 0, x_growth = 0, y_growth = 0;

   point_group_type expected_groups [$];
   point_group_type head;
   stim_row_type    stim_table [TABLE_ROWS];

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int fail_count    = 0;
   int quiet_cycles  = 0;
   int counted_items = 0;
   int start_beats   = 0;
   int step_beats    = 0;
   int idle_steps    = 0;
   int groups_seen   = 0;
   int ellipses_done = 0;

   ellipse_rasterizer_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_corner_x0 (req_corner_x0),
      .req_corner_y0 (req_corner_y0),
      .req_corner_x1 (req_corner_x1),
      .req_corner_y1 (req_corner_y1),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_left_col  (rsp_left_col),
      .rsp_right_col (rsp_right_col),
      .rsp_down_row  (rsp_down_row),
      .rsp_up_row    (rsp_up_row),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Wrap an error value to the unit's 48-bit two's complement width.
   function automatic longint wrap_err(longint v);
      logic signed [ERR_W-1:0] t;
      t = v[ERR_W-1:0];
      return longint'(t);
   endfunction

   // Advance the predictor by one accepted beat; returns 1 when the beat
   // produces a point group, which is written to g.
   function automatic bit raster_beat(input func_type f,
                                      input logic [COORD_W-1:0] x0, y0, x1, y1,
                                      output point_group_type g);
      longint a, b, odd, e;
      int     top;
      g = '0;
      if (f == FUNC_START) begin
         // Set up a new box; whatever was being drawn is dropped.
         a   = longint'((x1 > x0) ? x1 - x0 : x0 - x1);
         b   = longint'((y1 > y0) ? y1 - y0 : y0 - y1);
         odd = b & 1;
         top = int'((y0 < y1) ? y0 : y1);
         x_inc      = wrap_err(4 * (1 - a) * b * b);
         y_inc      = wrap_err(4 * (odd + 1) * a * a);
         err_acc    = wrap_err(wrap_err(x_inc + y_inc) + odd * a * a);
         left_at    = POS_W'((x0 < x1) ? x0 : x1);
         right_at   = POS_W'((x0 < x1) ? x1 : x0);
         down_at    = POS_W'(top + (b + 1) / 2);
         up_at      = POS_W'(down_at - odd);
         box_height = int'(b);
         y_growth   = 8 * a * a;
         x_growth   = 8 * b * b;
         draw_phase = DRAW_MAIN;
         return 1'b0;
      end
      if (draw_phase == DRAW_MAIN) begin
         e       = err_acc;
         g.left  = left_at;
         g.right = right_at;
         g.down  = down_at;
         g.up    = up_at;
         // Row half: compare twice the old error against the row increment.
         if (2 * e <= y_inc) begin
            down_at = POS_W'(down_at + 1);
            up_at   = POS_W'(up_at - 1);
            y_inc   = wrap_err(y_inc + y_growth);
            err_acc = wrap_err(err_acc + y_inc);
         end
         // Column half: uses the old error and the freshly updated one.
         if (2 * e >= x_inc || 2 * err_acc > y_inc) begin
            left_at  = POS_W'(left_at + 1);
            right_at = POS_W'(right_at - 1);
            x_inc    = wrap_err(x_inc + x_growth);
            err_acc  = wrap_err(err_acc + x_inc);
         end
         if (left_at > right_at) begin
            if (int'(down_at) - int'(up_at) < box_height)
               draw_phase = DRAW_TIP;
            else begin
               draw_phase = DRAW_IDLE;
               g.last     = 1'b1;
            end
         end
         return 1'b1;
      end
      if (draw_phase == DRAW_TIP) begin
         // Flat ellipses: finish the rows at the tips, one column out.
         g.left  = POS_W'(left_at - 1);
         g.right = POS_W'(right_at + 1);
         g.down  = down_at;
         g.up    = up_at;
         down_at = POS_W'(down_at + 1);
         up_at   = POS_W'(up_at - 1);
         if (int'(down_at) - int'(up_at) >= box_height) begin
            draw_phase = DRAW_IDLE;
            g.last     = 1'b1;
         end
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic stim_row_type stim(row_kind_type kind, func_type f,
                                         int x0, int y0, int x1, int y1, int pt);
      stim_row_type r;
      r.kind       = kind;
      r.func       = f;
      r.x0         = COORD_W'(x0);
      r.y0         = COORD_W'(y0);
      r.x1         = COORD_W'(x1);
      r.y1         = COORD_W'(y1);
      r.want.left  = POS_W'(pt);
      r.want.right = POS_W'(pt);
      r.want.down  = POS_W'(pt);
      r.want.up    = POS_W'(pt);
      r.want.last  = 1'b1;
      return r;
   endfunction

   // Place the second corner span away from c, either side, inside the grid.
   function automatic logic [COORD_W-1:0] far_corner(logic [COORD_W-1:0] c, int span);
      if (int'(c) + span <= COORD_MAX && (int'(c) < span || $urandom_range(0, 1) == 1))
         return COORD_W'(int'(c) + span);
      if (int'(c) >= span)
         return COORD_W'(int'(c) - span);
      return COORD_W'(COORD_MAX);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      fail_count++;
   endtask

   // Present one request beat at the falling edge, hold it until taken,
   // then run the predictor and queue what the beat should produce.
   task automatic send_beat(input stim_row_type r);
      point_group_type g;
      bit              has_group;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_func      = r.func;
      req_corner_x0 = r.x0;
      req_corner_y0 = r.y0;
      req_corner_x1 = r.x1;
      req_corner_y1 = r.y1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (r.func == FUNC_START)
         start_beats++;
      else
         step_beats++;
      // Steps on an idle block are ignored by the unit; leave them out of the count.
      if (r.func == FUNC_START || draw_phase != DRAW_IDLE)
         counted_items++;
      else
         idle_steps++;
      has_group = raster_beat(r.func, r.x0, r.y0, r.x1, r.y1, g);
      if (r.kind == ROW_GROUP)
         expected_groups.push_back(r.want);
      else if (r.kind == ROW_PREDICT && has_group)
         expected_groups.push_back(g);
   endtask

   // One random sequence: mostly a small box drawn to its last group, now
   // and then a huge box abandoned early, and a little plain noise.
   task automatic draw_sequence();
      stim_row_type r;
      int           roll, span_x, span_y;
      roll   = $urandom_range(0, 99);
      r      = '0;
      r.kind = ROW_PREDICT;
      if (roll < 6) begin
         r.func = func_type'($urandom_range(0, 1));
         r.x0   = COORD_W'($urandom);
         r.y0   = COORD_W'($urandom);
         r.x1   = COORD_W'($urandom);
         r.y1   = COORD_W'($urandom);
         send_beat(r);
         return;
      end
      span_x = (roll < 12) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 12);
      span_y = (roll < 12) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 12);
      r.func = FUNC_START;
      r.x0   = COORD_W'($urandom);
      r.y0   = COORD_W'($urandom);
      r.x1   = far_corner(r.x0, span_x);
      r.y1   = far_corner(r.y0, span_y);
      send_beat(r);
      r.func = FUNC_STEP;
      if (roll < 12) begin
         // Huge box: take a few groups, the next start abandons the rest.
         repeat ($urandom_range(1, 6)) send_beat(r);
      end else begin
         while (draw_phase != DRAW_IDLE && $urandom_range(0, 99) >= 3) send_beat(r);
         // Sometimes poke the finished block with steps that must give nothing.
         if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 2)) send_beat(r);
      end
   endtask

   // Receiver: stall at the falling edge at the current rate.
   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // Result check: every accepted beat on rsp_ pops the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_groups.size() == 0)
            report_mismatch($sformatf("group (%0d,%0d,%0d,%0d,%0b) with none pending",
                                      rsp_left_col, rsp_right_col, rsp_down_row,
                                      rsp_up_row, rsp_last));
         else begin
            head = expected_groups.pop_front();
            groups_seen++;
            if (head.last)
               ellipses_done++;
            if (rsp_left_col !== head.left)
               report_mismatch($sformatf("left_col got %0d want %0d",
                                         rsp_left_col, head.left));
            if (rsp_right_col !== head.right)
               report_mismatch($sformatf("right_col got %0d want %0d",
                                         rsp_right_col, head.right));
            if (rsp_down_row !== head.down)
               report_mismatch($sformatf("down_row got %0d want %0d",
                                         rsp_down_row, head.down));
            if (rsp_up_row !== head.up)
               report_mismatch($sformatf("up_row got %0d want %0d",
                                         rsp_up_row, head.up));
            if (rsp_last !== head.last)
               report_mismatch($sformatf("last got %0b want %0b", rsp_last, head.last));
         end
      end
   end

   // Watchdog: count cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] no beat accepted for %0d cycles, %0d groups still pending",
                  $time, quiet_cycles, expected_groups.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FUNC_STEP;
      req_corner_x0 = '0;
      req_corner_y0 = '0;
      req_corner_x1 = '0;
      req_corner_y1 = '0;

      // Directed table. Single-point boxes give one group at the corner,
      // flagged last, so those rows carry their answer; the rest predict.
      stim_table[0]  = stim(ROW_NONE,    FUNC_STEP,  0,    0,    0,    0,    0);   // idle step
      stim_table[1]  = stim(ROW_NONE,    FUNC_START, 5,    5,    5,    5,    0);
      stim_table[2]  = stim(ROW_GROUP,   FUNC_STEP,  0,    0,    0,    0,    5);
      stim_table[3]  = stim(ROW_NONE,    FUNC_STEP,  0,    0,    0,    0,    0);   // done
      stim_table[4]  = stim(ROW_NONE,    FUNC_START, 0,    0,    0,    0,    0);
      stim_table[5]  = stim(ROW_GROUP,   FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[6]  = stim(ROW_NONE,    FUNC_START, 4095, 4095, 4095, 4095, 0);
      stim_table[7]  = stim(ROW_GROUP,   FUNC_STEP,  4095, 4095, 4095, 4095, 4095);
      stim_table[8]  = stim(ROW_NONE,    FUNC_START, 10,   3,    2,    3,    0);   // flat line
      stim_table[9]  = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[10] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[11] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[12] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[13] = stim(ROW_NONE,    FUNC_START, 7,    20,   7,    12,   0);   // tip phase
      stim_table[14] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[15] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[16] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[17] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[18] = stim(ROW_NONE,    FUNC_START, 0,    0,    4095, 4095, 0);   // full grid
      stim_table[19] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[20] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[21] = stim(ROW_NONE,    FUNC_START, 4095, 4095, 0,    4094, 0);   // abandon
      stim_table[22] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[23] = stim(ROW_PREDICT, FUNC_STEP,  0,    0,    0,    0,    0);
      stim_table[24] = stim(ROW_NONE,    FUNC_START, 0,    4095, 3,    4086, 0);

      // Hold reset, then release it at a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part runs with no idling on either side.
      for (int i = 0; i < TABLE_ROWS; i++)
         send_beat(stim_table[i]);

      // Random part: four idle/stall mixes. Before each, drop valid and
      // hold off until every pending group has come back.
      for (int p = 0; p < 4; p++) begin
         @(negedge clock);
         req_valid = 1'b0;
         while (expected_groups.size() != 0) @(posedge clock);
         case (p)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 72; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
         endcase
         counted_items = 0;
         while (counted_items < PHASE_ITEMS) draw_sequence();
      end

      // Drain: wait for the last groups, then give the unit time to
      // show anything it should not produce.
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_groups.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d start beats and %0d step beats (%0d on an idle block)",
               start_beats, step_beats, idle_steps);
      $display("checked %0d point groups, %0d ellipses to their last group, %0d errors",
               groups_seen, ellipses_done, fail_count);
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
